[rtl/zhang_suen_thinning_core_assert.svh]
// Assertion macros for the thinning core.
// Used by the top level only; no other dependencies.
`ifndef ZHANG_SUEN_THINNING_CORE_ASSERT_SVH
`define ZHANG_SUEN_THINNING_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define ZST_ASSERT_IMP(lbl, clk, rst, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");
`define ZST_ASSERT_NXT(lbl, clk, rst, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define ZST_ASSERT_IMP(lbl, clk, rst, pre, post)
`define ZST_ASSERT_NXT(lbl, clk, rst, pre, post)
`endif
`endif

[rtl/zst_pkg.sv]
// Shared types and constants for the thinning core.
// No dependencies; used by the controller, datapath and top level.
`default_nettype none
package zst_pkg;
  localparam int COORD_W = 8;
  localparam int MAX_WIDTH = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int ADDR_W = 2 * COORD_W;
  localparam int NPIX = MAX_WIDTH * MAX_HEIGHT;
  localparam int DIM_W = 9;
  localparam int CNT_W = 17;
  localparam int PASS_W = 16;
  localparam int GRAY_W = 8;

  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_RUN   = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [GRAY_W-1:0]  gray_value;
  } req_t;

  typedef struct packed {
    logic [GRAY_W-1:0] pixel_out;
    logic [PASS_W-1:0] passes_done;
    logic [CNT_W-1:0]  changed_last;
  } rsp_t;

  typedef struct packed {
    logic [DIM_W-1:0]  width;
    logic [DIM_W-1:0]  height;
    logic [GRAY_W-1:0] level;
    logic [CNT_W-1:0]  stop;
  } cfg_t;

  typedef enum logic [1:0] {RD_REQ, RD_NB, RD_POS} rd_sel_t;

  typedef struct packed {
    logic    wr_req;
    rd_sel_t rd_sel;
    logic    latch_inside;
    logic    out_load;
    logic    out_read;
    logic    run_clr;
    logic    iter_init;
    logic    sub_set;
    logic    count_init;
    logic    scan_init;
    logic    nb_step;
    logic    mark_wr;
    logic    scan_adv;
    logic    apply_chk;
    logic    count_chk;
    logic    iter_end;
  } cmd_t;

  typedef struct packed {
    logic out_valid;
    logic scan_last;
    logic nb_last;
    logic sub;
    logic first;
    logic stop;
  } stat_t;
endpackage
`default_nettype wire

[rtl/zst_datapath.sv]
// Datapath: frame and mark memories, scan position, neighbor gather, counters.
// Depends on zst_pkg; driven by zst_ctrl commands.
`default_nettype none
module zst_datapath (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire zst_pkg::cfg_t cfg,
  input  wire zst_pkg::req_t req,
  input  wire zst_pkg::cmd_t cmd,
  input  wire logic         out_ready,
  output zst_pkg::stat_t    stat,
  output zst_pkg::rsp_t     out_data
);
  localparam int CW = zst_pkg::COORD_W;

  logic frame_mem [0:zst_pkg::NPIX-1];
  logic mark_mem  [0:zst_pkg::NPIX-1];
  logic frame_q, mark_q;

  logic [CW-1:0] r, c;
  logic full;
  logic [3:0] k;
  logic [6:0] nb;
  logic inside_q;
  logic sub, first;
  logic [zst_pkg::CNT_W-1:0] removed, ones, change;
  logic [zst_pkg::PASS_W-1:0] pass;
  logic out_valid;

  logic [CW-1:0] rend, cend, rbeg;
  logic [zst_pkg::DIM_W-1:0] h_off, w_off;
  logic scan_last;
  logic [CW-1:0] nr, nc;
  logic [zst_pkg::ADDR_W-1:0] raddr, waddr, pos;
  logic fwe, wbit, in_inside;
  logic [7:0] n;
  logic [3:0] trans, cnt1;
  logic m1, m2, mark;
  logic [zst_pkg::CNT_W-1:0] iter_cnt;

  assign h_off = full ? zst_pkg::DIM_W'(1) : zst_pkg::DIM_W'(2);
  assign w_off = full ? zst_pkg::DIM_W'(1) : zst_pkg::DIM_W'(2);
  assign rend = CW'(cfg.height - h_off);
  assign cend = CW'(cfg.width - w_off);
  assign rbeg = full ? CW'(0) : CW'(1);
  assign scan_last = (r == rend) && (c == cend);
  assign pos = {r, c};

  always_comb begin
    nr = r;
    nc = c;
    case (k[2:0])
      3'd0: begin nr = r - 1'b1; end
      3'd1: begin nr = r - 1'b1; nc = c + 1'b1; end
      3'd2: begin nc = c + 1'b1; end
      3'd3: begin nr = r + 1'b1; nc = c + 1'b1; end
      3'd4: begin nr = r + 1'b1; end
      3'd5: begin nr = r + 1'b1; nc = c - 1'b1; end
      3'd6: begin nc = c - 1'b1; end
      default: begin nr = r - 1'b1; nc = c - 1'b1; end
    endcase
  end

  always_comb begin
    case (cmd.rd_sel)
      zst_pkg::RD_REQ: raddr = {req.row, req.col};
      zst_pkg::RD_NB:  raddr = {nr, nc};
      default:         raddr = pos;
    endcase
  end

  assign in_inside = ({1'b0, req.col} < cfg.width) && ({1'b0, req.row} < cfg.height);
  assign fwe = (cmd.wr_req && in_inside) || (cmd.apply_chk && frame_q && mark_q);
  assign waddr = cmd.wr_req ? {req.row, req.col} : pos;
  assign wbit = cmd.wr_req ? (req.gray_value > cfg.level) : 1'b0;

  // Ring p2..p9; the last neighbor arrives straight from the memory.
  assign n = {frame_q, nb};
  always_comb begin
    trans = '0;
    cnt1 = '0;
    for (int i = 0; i < 8; i++) begin
      cnt1 = cnt1 + 4'(n[i]);
      if (!n[i] && n[(i + 1) % 8]) trans = trans + 4'd1;
    end
    if (!sub) begin
      m1 = n[0] & n[2] & n[4];
      m2 = n[2] & n[4] & n[6];
    end else begin
      m1 = n[0] & n[2] & n[6];
      m2 = n[0] & n[4] & n[6];
    end
    mark = (trans == 4'd1) && (cnt1 >= 4'd2) && (cnt1 <= 4'd6) && !m1 && !m2;
  end

  assign iter_cnt = first ? ones : removed;

  always_ff @(posedge clk) begin
    if (fwe) begin
      frame_mem[waddr] <= wbit;
    end
    frame_q <= frame_mem[raddr];
    if (cmd.mark_wr) begin
      mark_mem[pos] <= mark;
    end
    mark_q <= mark_mem[pos];
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_inside) begin
      inside_q <= in_inside;
    end
    if (cmd.nb_step && k != 4'd0 && k != 4'd8) begin
      nb[3'(k - 4'd1)] <= frame_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r <= '0;
      c <= '0;
      full <= 1'b0;
      k <= '0;
      sub <= 1'b0;
      first <= 1'b0;
      removed <= '0;
      ones <= '0;
      change <= '0;
      pass <= '0;
      out_valid <= 1'b0;
      out_data <= '0;
    end else begin
      if (cmd.iter_init || cmd.sub_set) begin
        r <= CW'(1);
        c <= CW'(1);
        full <= 1'b0;
        k <= '0;
        sub <= cmd.sub_set;
      end else if (cmd.count_init) begin
        r <= '0;
        c <= '0;
        full <= 1'b1;
        ones <= '0;
      end else if (cmd.scan_init) begin
        // rewind to the first interior pixel for the clear walk
        r <= CW'(1);
        c <= CW'(1);
        k <= '0;
      end else begin
        if (cmd.nb_step) begin
          k <= (k == 4'd8) ? 4'd0 : k + 4'd1;
        end
        if (cmd.scan_adv) begin
          if (c == cend) begin
            c <= rbeg;
            r <= r + 1'b1;
          end else begin
            c <= c + 1'b1;
          end
        end
      end
      if (cmd.iter_init) begin
        removed <= '0;
      end else if (cmd.apply_chk && frame_q && mark_q) begin
        removed <= removed + 1'b1;
      end
      if (cmd.count_chk && frame_q) begin
        ones <= ones + 1'b1;
      end
      if (cmd.run_clr) begin
        pass <= '0;
        first <= 1'b1;
      end else if (cmd.iter_end) begin
        first <= 1'b0;
        change <= iter_cnt;
        if (pass != '1) pass <= pass + 1'b1;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
        out_data.pixel_out <= (cmd.out_read && inside_q && frame_q) ? 8'd255 : 8'd0;
        out_data.passes_done <= pass;
        out_data.changed_last <= change;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign stat.out_valid = out_valid;
  assign stat.scan_last = scan_last;
  assign stat.nb_last = (k == 4'd8);
  assign stat.sub = sub;
  assign stat.first = first;
  assign stat.stop = (iter_cnt <= cfg.stop);
endmodule
`default_nettype wire

[rtl/zst_ctrl.sv]
// Controller: request decode and the thinning run sequencer.
// Depends on zst_pkg; commands zst_datapath.
`default_nettype none
module zst_ctrl (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  input  wire logic [1:0] req_type,
  input  wire logic      out_ready,
  input  wire zst_pkg::stat_t stat,
  output logic           in_ready,
  output zst_pkg::cmd_t  cmd
);
  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_MARK, S_APPLY_RD, S_APPLY_CHK,
    S_COUNT_RD, S_COUNT_CHK, S_ITER_END, S_FINISH
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE) && (!stat.out_valid || out_ready);

  always_comb begin
    cmd = '0;
    cmd.rd_sel = zst_pkg::RD_POS;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        cmd.rd_sel = zst_pkg::RD_REQ;
        if (in_valid && in_ready) begin
          unique case (req_type)
            zst_pkg::REQ_WRITE: begin
              cmd.wr_req = 1'b1;
              cmd.out_load = 1'b1;
            end
            zst_pkg::REQ_RUN: begin
              cmd.run_clr = 1'b1;
              cmd.iter_init = 1'b1;
              state_next = S_MARK;
            end
            zst_pkg::REQ_READ: begin
              cmd.latch_inside = 1'b1;
              state_next = S_READ;
            end
            default: begin
              cmd.out_load = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        cmd.out_load = 1'b1;
        cmd.out_read = 1'b1;
        state_next = S_IDLE;
      end
      S_MARK: begin
        cmd.rd_sel = zst_pkg::RD_NB;
        cmd.nb_step = 1'b1;
        if (stat.nb_last) begin
          cmd.mark_wr = 1'b1;
          if (stat.scan_last) begin
            cmd.scan_init = 1'b1;
            state_next = S_APPLY_RD;
          end else begin
            cmd.scan_adv = 1'b1;
          end
        end
      end
      S_APPLY_RD: begin
        state_next = S_APPLY_CHK;
      end
      S_APPLY_CHK: begin
        cmd.apply_chk = 1'b1;
        if (!stat.scan_last) begin
          cmd.scan_adv = 1'b1;
          state_next = S_APPLY_RD;
        end else if (!stat.sub) begin
          cmd.sub_set = 1'b1;
          state_next = S_MARK;
        end else if (stat.first) begin
          cmd.count_init = 1'b1;
          state_next = S_COUNT_RD;
        end else begin
          state_next = S_ITER_END;
        end
      end
      S_COUNT_RD: begin
        state_next = S_COUNT_CHK;
      end
      S_COUNT_CHK: begin
        cmd.count_chk = 1'b1;
        if (stat.scan_last) begin
          state_next = S_ITER_END;
        end else begin
          cmd.scan_adv = 1'b1;
          state_next = S_COUNT_RD;
        end
      end
      S_ITER_END: begin
        cmd.iter_end = 1'b1;
        if (stat.stop) begin
          state_next = S_FINISH;
        end else begin
          cmd.iter_init = 1'b1;
          state_next = S_MARK;
        end
      end
      S_FINISH: begin
        cmd.out_load = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end
endmodule
`default_nettype wire

[rtl/zhang_suen_thinning_core.sv]
// Zhang-Suen thinning core: top level with the register port and output slot.
// Built from zst_ctrl and zst_datapath; types from zst_pkg.
// Requests enter on in_valid/in_ready as req_t: write pixel, run thinning,
// read pixel. Every request yields one response on out_valid/out_ready with
// the read pixel (0 or 255), the pass count and the final change count.
// A write or unknown request responds in the next cycle, a read after S_READ.
// A run walks the frame through one shared frame memory read port:
// per iteration each subpass gathers the ring of every interior pixel
// and then walks the interior pixels again to clear marked pixels, and the
// first iteration adds a walk over every frame pixel to count the ones left.
// One response waits in the output register; a new request is taken while
// the response is being taken, and none while it stalls there.
// Reset clears the registers, counters and control; the frame itself holds
// whatever was written and must be written before it is read or thinned.
// Registers sit at byte address 4*i: width, height, binarize level, stop
// count. Write them only while no request is in flight.
`default_nettype none
`include "zhang_suen_thinning_core_assert.svh"
module zhang_suen_thinning_core (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire zst_pkg::req_t in_data,
  output logic              out_valid,
  input  wire logic         out_ready,
  output zst_pkg::rsp_t     out_data,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [3:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_LEVEL  = 2'd2;
  localparam logic [1:0] REG_STOP   = 2'd3;

  logic [zst_pkg::DIM_W-1:0]  frame_width, frame_height;
  logic [zst_pkg::GRAY_W-1:0] binarize_level;
  logic [zst_pkg::CNT_W-1:0]  stop_count;
  zst_pkg::cfg_t  cfg;
  zst_pkg::cmd_t  cmd;
  zst_pkg::stat_t stat;
  logic wr_take;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width <= zst_pkg::DIM_W'(zst_pkg::MAX_WIDTH);
      frame_height <= zst_pkg::DIM_W'(zst_pkg::MAX_HEIGHT);
      binarize_level <= zst_pkg::GRAY_W'(1);
      stop_count <= zst_pkg::CNT_W'(10);
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_WIDTH:  frame_width <= pwdata[zst_pkg::DIM_W-1:0];
        REG_HEIGHT: frame_height <= pwdata[zst_pkg::DIM_W-1:0];
        REG_LEVEL:  binarize_level <= pwdata[zst_pkg::GRAY_W-1:0];
        default:    stop_count <= pwdata[zst_pkg::CNT_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_WIDTH:  prdata = 32'(frame_width);
      REG_HEIGHT: prdata = 32'(frame_height);
      REG_LEVEL:  prdata = 32'(binarize_level);
      default:    prdata = 32'(stop_count);
    endcase
  end

  // Clamp the frame size to at least 3 and at most what the memory holds.
  always_comb begin
    cfg.width = frame_width;
    if (frame_width < zst_pkg::DIM_W'(3)) cfg.width = zst_pkg::DIM_W'(3);
    else if (frame_width > zst_pkg::DIM_W'(zst_pkg::MAX_WIDTH))
      cfg.width = zst_pkg::DIM_W'(zst_pkg::MAX_WIDTH);
    cfg.height = frame_height;
    if (frame_height < zst_pkg::DIM_W'(3)) cfg.height = zst_pkg::DIM_W'(3);
    else if (frame_height > zst_pkg::DIM_W'(zst_pkg::MAX_HEIGHT))
      cfg.height = zst_pkg::DIM_W'(zst_pkg::MAX_HEIGHT);
    cfg.level = binarize_level;
    cfg.stop = stop_count;
  end

  zst_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .req_type  (in_data.req_type),
    .out_ready (out_ready),
    .stat      (stat),
    .in_ready  (in_ready),
    .cmd       (cmd)
  );

  zst_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .req       (in_data),
    .cmd       (cmd),
    .out_ready (out_ready),
    .stat      (stat),
    .out_data  (out_data)
  );

  assign out_valid = stat.out_valid;
  assign wr_take = in_valid && in_ready && (in_data.req_type == zst_pkg::REQ_WRITE);

  `ZST_ASSERT_NXT(a_write_responds, clk, rst, wr_take, out_valid)
  `ZST_ASSERT_IMP(a_stall_blocks, clk, rst, out_valid && !out_ready, !in_ready)
  `ZST_ASSERT_IMP(a_one_step, clk, rst, cmd.out_load, !cmd.iter_end && !cmd.run_clr)
endmodule
`default_nettype wire
